[design/bdpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the button debounce and press classifier.
// Holds the register index codes, field widths and register reset values.
// No dependencies.
package bdpc_pkg;

   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned IndexWidth = 2;

   typedef enum logic [IndexWidth-1:0] {
      REG_DEBOUNCE  = 2'd0,
      REG_SHORT_MAX = 2'd1,
      REG_LONG      = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_index_type;

   localparam logic [CfgWidth-1:0] DebounceReset = 16'd15;
   localparam logic [CfgWidth-1:0] ShortMaxReset = 16'd1000;
   localparam logic [CfgWidth-1:0] LongReset     = 16'd3000;

   localparam logic LevelReleased = 1'b1;
   localparam logic LevelPressed  = 1'b0;

endpackage

[design/button_debounce_press_classifier_core.sv]
`timescale 1ns / 1ps
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg for register codes, widths and reset values.
//
// Usage:
// The request channel (req_valid, req_stall) carries one raw active-low pin
// sample with its 32-bit millisecond timestamp per transaction. The response
// channel (rsp_valid, rsp_stall) returns exactly one transaction per request
// with the press, release, short-press and long-press flags and the
// debounced level after that sample.
// A request accepted into the input register is evaluated there against the
// filter state, and its flags are then captured in the response register.
// One request per cycle is sustained while the receiver does not stall; the
// rate is set by the single evaluation stage, whose two 32-bit elapsed-time
// subtractions and their three compares run in parallel.
// When the receiver stalls, the response register holds, the input register
// holds any sample, and req_stall rises when it is full: no request enters.
// The configuration port (csr_valid, csr_ready, csr_index, csr_wdata) is
// always ready; writes take effect from the next evaluated request. Indexes
// beyond the register list are ignored.
// Synchronous reset empties both stages, restores the register defaults
// (15, 1000, 3000 ms) and returns the filter to the released level.
module button_debounce_press_classifier_core
   import bdpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pin_level,
   input  logic [TimeWidth-1:0] req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_press_event,
   output logic                 rsp_release_event,
   output logic                 rsp_short_press_event,
   output logic                 rsp_long_press_event,
   output logic                 rsp_stable_level,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]  csr_wdata
);

   logic [CfgWidth-1:0]  debounce_ms_ff, short_max_ms_ff, long_press_ms_ff;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_level_ff;
   logic [TimeWidth-1:0] s1_now_ff;

   logic                 filter_level_ff, filter_level_in;
   logic                 debounce_active_ff, debounce_active_in;
   logic [TimeWidth-1:0] debounce_start_ff, debounce_start_in;
   logic                 accepted_level_ff, accepted_level_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic                 long_armed_ff, long_armed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 press_in, release_in, short_in, long_in;
   logic                 press_ff, release_ff, short_ff, long_ff;

   logic                 out_free, req_load, evaluate;
   logic [TimeWidth-1:0] debounce_elapsed, hold_elapsed;
   logic                 level_changed;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_load  = req_valid && !req_stall;
   assign evaluate  = s1_valid_ff && out_free;

   assign s1_valid_in  = req_load ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = evaluate ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   // Evaluation of one sample against the filter state.
   always_comb begin
      level_changed      = s1_level_ff != filter_level_ff;
      filter_level_in    = s1_level_ff;
      debounce_active_in = debounce_active_ff || level_changed;
      debounce_start_in  = level_changed ? s1_now_ff : debounce_start_ff;
      debounce_elapsed   = s1_now_ff - debounce_start_in;
      accepted_level_in  = accepted_level_ff;
      if (debounce_active_in &&
          debounce_elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_ms_ff}) begin
         accepted_level_in  = s1_level_ff;
         debounce_active_in = 1'b0;
      end

      hold_elapsed   = s1_now_ff - press_start_ff;
      press_in       = 1'b0;
      release_in     = 1'b0;
      short_in       = 1'b0;
      long_in        = 1'b0;
      press_start_in = press_start_ff;
      long_armed_in  = long_armed_ff;
      if (accepted_level_in != accepted_level_ff) begin
         if (accepted_level_in == LevelPressed) begin
            press_in       = 1'b1;
            press_start_in = s1_now_ff;
            long_armed_in  = 1'b1;
         end else begin
            release_in    = 1'b1;
            short_in      = hold_elapsed <=
                            {{(TimeWidth-CfgWidth){1'b0}}, short_max_ms_ff};
            long_armed_in = 1'b0;
         end
      end else if (long_armed_ff &&
                   hold_elapsed > {{(TimeWidth-CfgWidth){1'b0}}, long_press_ms_ff}) begin
         long_in       = 1'b1;
         long_armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff     <= DebounceReset;
         short_max_ms_ff    <= ShortMaxReset;
         long_press_ms_ff   <= LongReset;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         filter_level_ff    <= LevelReleased;
         debounce_active_ff <= 1'b0;
         debounce_start_ff  <= '0;
         accepted_level_ff  <= LevelReleased;
         press_start_ff     <= '0;
         long_armed_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_DEBOUNCE:  debounce_ms_ff   <= csr_wdata;
               REG_SHORT_MAX: short_max_ms_ff  <= csr_wdata;
               REG_LONG:      long_press_ms_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (evaluate) begin
            filter_level_ff    <= filter_level_in;
            debounce_active_ff <= debounce_active_in;
            debounce_start_ff  <= debounce_start_in;
            accepted_level_ff  <= accepted_level_in;
            press_start_ff     <= press_start_in;
            long_armed_ff      <= long_armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         s1_level_ff <= req_pin_level;
         s1_now_ff   <= req_now_ms;
      end
      if (evaluate) begin
         press_ff   <= press_in;
         release_ff <= release_in;
         short_ff   <= short_in;
         long_ff    <= long_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_press_event       = press_ff;
   assign rsp_release_event     = release_ff;
   assign rsp_short_press_event = short_ff;
   assign rsp_long_press_event  = long_ff;
   assign rsp_stable_level      = accepted_level_ff;

endmodule

[design/bdpc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the button debounce and press classifier.
// Depends on bdpc_pkg; bound to button_debounce_press_classifier_core below.
module bdpc_checker
   import bdpc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_press_event,
   input logic                  rsp_release_event,
   input logic                  rsp_short_press_event,
   input logic                  rsp_long_press_event,
   input logic                  rsp_stable_level
);

   // A press transaction must report the pressed level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_event |-> rsp_stable_level == LevelPressed)
      else $error("press event without pressed level");

   // A release transaction must report the released level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_event |-> rsp_stable_level == LevelReleased)
      else $error("release event without released level");

   // A short press is only ever reported together with its release.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_press_event |-> rsp_release_event)
      else $error("short press without release");

   // At most one of press, release and long press per transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_press_event, rsp_release_event, rsp_long_press_event}))
      else $error("conflicting events in one transaction");

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (.*);

[tb/button_debounce_press_classifier_core_test.sv]
`timescale 1ns / 1ps
// Testbench for button_debounce_press_classifier_core: directed table, then random pin traffic.
// Results are checked against an in-bench model or pinned row flags; needs bdpc_pkg and core.
module button_debounce_press_classifier_core_test;
   import bdpc_pkg::*;

   typedef struct packed {
      logic press;
      logic rel;
      logic short_hold;
      logic long_hold;
      logic level;
   } press_flags_type;

   typedef struct packed {
      bit              wr;
      reg_index_type   wr_index;
      logic [15:0]     wr_data;
      logic            level;
      logic [31:0]     stamp;
      bit              pinned;
      press_flags_type want;
   } press_row_type;

   typedef struct packed {
      logic [15:0] dbc;
      logic [15:0] shrt;
      logic [15:0] lng;
   } timing_set_type;

   localparam press_flags_type NoneHeld     = 5'b00000;
   localparam press_flags_type NoneReleased = 5'b00001;
   localparam press_flags_type PressSeen    = 5'b10000;
   localparam press_flags_type LongSeen     = 5'b00010;
   localparam press_flags_type ReleaseLong  = 5'b01001;
   localparam press_flags_type ReleaseShort = 5'b01101;

   localparam int QuietLimit    = 1000;
   localparam int PhaseItems    = 204;
   localparam int PressureFirst = 300;
   localparam int PressureLast  = 380;
   localparam int HoldOffCycles = 150;

   localparam press_row_type DirectedRows [0:26] = '{
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd0,          1'b1, NoneReleased},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd100,        1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd115,        1'b1, PressSeen},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd3115,       1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd3116,       1'b1, LongSeen},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd9000,       1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd9015,       1'b1, ReleaseLong},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd10000,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd10015,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd11000,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd11015,      1'b1, ReleaseShort},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd12000,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd12005,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd12020,      1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'hFFFF_FFF8,  1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'h0000_0007,  1'b1, PressSeen},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd100,        1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd115,        1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd1000,       1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd990,        1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b0, 32'd980,        1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd5000,       1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd5015,       1'b0, NoneHeld},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'hFFFF_FFFF,  1'b0, NoneHeld},
      '{1'b1, REG_DEBOUNCE, 16'd0, 1'b0, 32'd20000,      1'b1, PressSeen},
      '{1'b0, REG_DEBOUNCE, 16'd0, 1'b1, 32'd20001,      1'b1, ReleaseShort},
      '{1'b1, REG_UNUSED, 16'hFFFF, 1'b0, 32'd20002,     1'b1, PressSeen}
   };

   localparam timing_set_type TimingSets [0:6] = '{
      '{16'd0,     16'd0,     16'd0},
      '{16'd65535, 16'd65535, 16'd65535},
      '{16'd4,     16'd30,    16'd90},
      '{16'd10,    16'd200,   16'd150},
      '{16'd0,     16'd65535, 16'd1},
      '{16'd65535, 16'd0,     16'd65535},
      '{16'd20,    16'd100,   16'd400}
   };

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_pin_level;
   logic [31:0]   req_now_ms;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_press_event;
   logic          rsp_release_event;
   logic          rsp_short_press_event;
   logic          rsp_long_press_event;
   logic          rsp_stable_level;
   logic          csr_valid;
   logic          csr_ready;
   reg_index_type csr_index;
   logic [15:0]   csr_wdata;

   // Classifier model state and its copy of the timing registers.
   logic [15:0] cfg_debounce  = DebounceReset;
   logic [15:0] cfg_short_max = ShortMaxReset;
   logic [15:0] cfg_long      = LongReset;
   logic        raw_level     = LevelReleased;
   logic        settling      = 1'b0;
   logic [31:0] settle_from   = 32'd0;
   logic        held_level    = LevelReleased;
   logic        last_held     = LevelReleased;
   logic [31:0] hold_from     = 32'd0;
   logic        long_pending  = 1'b0;

   press_flags_type pending_flags[$];
   bit              drv_pinned;
   press_flags_type drv_want;
   int              error_count;
   int              result_count;
   int              sent_count;
   int              quiet_cycles;

   button_debounce_press_classifier_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pin_level         (req_pin_level),
      .req_now_ms            (req_now_ms),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_press_event       (rsp_press_event),
      .rsp_release_event     (rsp_release_event),
      .rsp_short_press_event (rsp_short_press_event),
      .rsp_long_press_event  (rsp_long_press_event),
      .rsp_stable_level      (rsp_stable_level),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic press_flags_type classify_sample(input logic lvl,
                                                       input logic [31:0] now);
      press_flags_type flags;
      logic [31:0]     held_for;
      flags = NoneHeld;
      if (lvl != raw_level) begin
         raw_level   = lvl;
         settling    = 1'b1;
         settle_from = now;
      end
      if (settling && (now - settle_from) >= {16'd0, cfg_debounce}) begin
         held_level = raw_level;
         settling   = 1'b0;
      end
      if (held_level != last_held) begin
         if (held_level == LevelPressed) begin
            flags.press  = 1'b1;
            hold_from    = now;
            long_pending = 1'b1;
         end else begin
            held_for         = now - hold_from;
            flags.short_hold = (held_for <= {16'd0, cfg_short_max});
            flags.rel        = 1'b1;
            long_pending     = 1'b0;
         end
         last_held = held_level;
      end
      if (long_pending && (now - hold_from) > {16'd0, cfg_long}) begin
         flags.long_hold = 1'b1;
         long_pending    = 1'b0;
      end
      flags.level = held_level;
      return flags;
   endfunction

   always @(posedge clock) begin
      press_flags_type seen;
      press_flags_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEBOUNCE:  cfg_debounce  = csr_wdata;
               REG_SHORT_MAX: cfg_short_max = csr_wdata;
               REG_LONG:      cfg_long      = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = classify_sample(req_pin_level, req_now_ms);
            if (drv_pinned) want = drv_want;
            pending_flags.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_press_event, rsp_release_event, rsp_short_press_event,
                    rsp_long_press_event, rsp_stable_level};
            if (pending_flags.size() == 0) begin
               if (error_count < 10)
                  $display("Result %0d arrived with nothing expected: %b", result_count, seen);
               error_count++;
            end else begin
               want = pending_flags.pop_front();
               if (seen != want) begin
                  if (error_count < 10)
                     $display({"Result %0d: expected press=%b rel=%b short=%b long=%b lvl=%b,",
                               " got press=%b rel=%b short=%b long=%b lvl=%b"},
                              result_count, want.press, want.rel, want.short_hold,
                              want.long_hold, want.level, seen.press, seen.rel,
                              seen.short_hold, seen.long_hold, seen.level);
                  error_count++;
               end
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int  hold_n;
      int  taken;
      bit  held_off;
      taken    = 0;
      held_off = 1'b0;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (taken == PressureFirst && !held_off) begin
            held_off  = 1'b1;
            rsp_stall = 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
         end else begin
            hold_n = ((taken / 50) % 3 == 0) ? 0 : $urandom_range(0, 18);
            if (hold_n > 0) begin
               rsp_stall = 1'b1;
               repeat (hold_n) @(negedge clock);
            end
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic lvl, input logic [31:0] stamp, input bit pinned,
                              input press_flags_type want);
      int gap;
      if (sent_count >= PressureFirst && sent_count < PressureLast)
         gap = 0;
      else if ((sent_count / 40) % 3 == 0)
         gap = 0;
      else
         gap = $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_pin_level = lvl;
      req_now_ms    = stamp;
      drv_pinned    = pinned;
      drv_want      = want;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle;
      req_valid = 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic        target;
      logic        lvl;
      logic [31:0] stamp;
      int unsigned top_ms;
      int unsigned span;
      int          pick;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pin_level = LevelReleased;
      req_now_ms    = 32'd0;
      csr_valid     = 1'b0;
      csr_index     = REG_DEBOUNCE;
      csr_wdata     = 16'd0;
      drv_pinned    = 1'b0;
      drv_want      = NoneHeld;
      error_count   = 0;
      result_count  = 0;
      sent_count    = 0;
      quiet_cycles  = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (DirectedRows[i]) begin
         if (DirectedRows[i].wr) begin
            wait_idle();
            write_reg(DirectedRows[i].wr_index, DirectedRows[i].wr_data);
         end
         send_sample(DirectedRows[i].level, DirectedRows[i].stamp, DirectedRows[i].pinned,
                     DirectedRows[i].want);
      end

      foreach (TimingSets[p]) begin
         wait_idle();
         write_reg(REG_DEBOUNCE, TimingSets[p].dbc);
         write_reg(REG_SHORT_MAX, TimingSets[p].shrt);
         write_reg(REG_LONG, TimingSets[p].lng);
         top_ms = TimingSets[p].dbc;
         if (TimingSets[p].shrt > top_ms) top_ms = TimingSets[p].shrt;
         if (TimingSets[p].lng > top_ms) top_ms = TimingSets[p].lng;
         span   = top_ms / 6 + 2;
         stamp  = $urandom;
         target = LevelReleased;
         for (int n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 11) == 0) target = ~target;
            lvl  = ($urandom_range(0, 7) == 0) ? ~target : target;
            pick = $urandom_range(0, 39);
            if (pick == 0)
               stamp = $urandom;
            else if (pick >= 4 && pick <= 9)
               stamp = stamp + $urandom_range(0, TimingSets[p].dbc + 1);
            else if (pick > 9)
               stamp = stamp + $urandom_range(1, span);
            send_sample(lvl, stamp, 1'b0, NoneHeld);
         end
      end

      req_valid = 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      error_count += pending_flags.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
